### sv/qhd_pkg.sv
// shared types, constants and the cordic angle table of the quaternion heading decoder
package qhd_pkg;

  localparam int VEC_W      = 34;
  localparam int CW         = 36;
  localparam int ZW         = 34;
  localparam int ZFRAC      = 24;
  localparam int ACC_N_W    = 23;
  localparam int ACC_PROD_W = 47;
  localparam int RECIP_SH   = 29;
  localparam int ACC_W      = 18;
  localparam int ACC_DIV    = 50;
  localparam logic [23:0] RECIP = 24'd10737419;
  localparam logic [30:0] DEG90 = 31'd90 << ZFRAC;

  typedef logic signed [VEC_W-1:0] vec_t;

  typedef struct packed {
    logic                  ok;
    vec_t                  az_x;
    vec_t                  az_y;
    vec_t                  el_x;
    vec_t                  el_y;
    logic [ACC_N_W-1:0]    acc_n;
    logic                  acc_neg;
    logic [ACC_PROD_W-1:0] acc_prod;
  } qhd_item_t;

  // atan(2^-n) in degrees, q24
  function automatic logic [29:0] atan_deg(input int n);
    logic [29:0] v;
    case (n)
      0: v = 30'd754974720;
      1: v = 30'd445687602;
      2: v = 30'd235489088;
      3: v = 30'd119537938;
      4: v = 30'd60000934;
      5: v = 30'd30029717;
      6: v = 30'd15018523;
      7: v = 30'd7509720;
      8: v = 30'd3754917;
      9: v = 30'd1877466;
      10: v = 30'd938734;
      11: v = 30'd469367;
      12: v = 30'd234684;
      13: v = 30'd117342;
      14: v = 30'd58671;
      15: v = 30'd29335;
      16: v = 30'd14668;
      17: v = 30'd7334;
      18: v = 30'd3667;
      19: v = 30'd1833;
      20: v = 30'd917;
      21: v = 30'd458;
      22: v = 30'd229;
      23: v = 30'd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/qhd_front.sv
// front end: length check, quaternion products, vector sums and acceleration scaling
module qhd_front import qhd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [9:0]       frame_length,
  input  logic signed [15:0] quat_i,
  input  logic signed [15:0] quat_j,
  input  logic signed [15:0] quat_k,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] accel_raw,
  output logic             out_valid,
  output qhd_item_t        out_item
);

  logic                a_valid;
  logic                a_ok;
  logic signed [31:0]  p_ii, p_jj, p_kk, p_ww, p_ij, p_kw, p_jk, p_iw;
  logic [ACC_N_W-1:0]  a_acc_n;
  logic                a_acc_neg;
  logic signed [23:0]  num;
  logic signed [23:0]  num_neg;
  logic signed [VEC_W-1:0] s_az, s_el;

  assign num     = $signed({accel_raw[15], accel_raw, 7'b0}) + 24'sd25;
  assign num_neg = 24'sd49 - num;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_ok      <= (frame_length == 10'd16);
    p_ii      <= quat_i * quat_i;
    p_jj      <= quat_j * quat_j;
    p_kk      <= quat_k * quat_k;
    p_ww      <= quat_w * quat_w;
    p_ij      <= quat_i * quat_j;
    p_kw      <= quat_k * quat_w;
    p_jk      <= quat_j * quat_k;
    p_iw      <= quat_i * quat_w;
    a_acc_neg <= num[23];
    a_acc_n   <= num[23] ? num_neg[ACC_N_W-1:0] : num[ACC_N_W-1:0];
  end

  assign s_az = VEC_W'(p_ij) + VEC_W'(p_kw);
  assign s_el = VEC_W'(p_jk) + VEC_W'(p_iw);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
    out_item.ok       <= a_ok;
    out_item.az_y     <= s_az <<< 1;
    out_item.az_x     <= VEC_W'(p_ii) - VEC_W'(p_jj) - VEC_W'(p_kk) + VEC_W'(p_ww);
    out_item.el_y     <= s_el <<< 1;
    out_item.el_x     <= VEC_W'(p_kk) + VEC_W'(p_ww) - VEC_W'(p_ii) - VEC_W'(p_jj);
    out_item.acc_n    <= a_acc_n;
    out_item.acc_neg  <= a_acc_neg;
    out_item.acc_prod <= ACC_PROD_W'(a_acc_n) * ACC_PROD_W'(RECIP);
  end

endmodule

### sv/qhd_queue.sv
// two-entry request queue between front and back
module qhd_queue import qhd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  qhd_item_t push_item,
  output logic      full,
  output logic      pop_valid,
  output qhd_item_t pop_item
);

  qhd_item_t  mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_item  = mem[rptr];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (pop_valid) begin
        rptr <= !rptr;
      end
      count <= count + 2'(do_push) - 2'(pop_valid);
    end
    if (do_push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

### sv/qhd_cordic.sv
// pipelined vectoring cordic atan2 in degrees, q24
module qhd_cordic import qhd_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic              clk,
  input  vec_t              x_in,
  input  vec_t              y_in,
  output logic signed [ZW-1:0] z_out
);

  logic signed [CW-1:0] xr [STAGES+1];
  logic signed [CW-1:0] yr [STAGES+1];
  logic signed [ZW-1:0] zr [STAGES+1];
  logic                 zf [STAGES+1];

  logic signed [CW-1:0] xe, ye, x0, y0;
  logic signed [ZW-1:0] z0;

  assign xe = CW'(x_in);
  assign ye = CW'(y_in);

  always_comb begin
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        z0 = $signed(ZW'(DEG90));
        x0 = ye;
        y0 = -xe;
      end else begin
        z0 = -$signed(ZW'(DEG90));
        x0 = -ye;
        y0 = xe;
      end
    end
  end

  always_ff @(posedge clk) begin
    xr[0] <= x0;
    yr[0] <= y0;
    zr[0] <= z0;
    zf[0] <= (xe == 0) && (ye == 0);
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!yr[g][CW-1]) begin
        xr[g+1] <= xr[g] + (yr[g] >>> g);
        yr[g+1] <= yr[g] - (xr[g] >>> g);
        zr[g+1] <= zr[g] + $signed(ZW'(atan_deg(g)));
      end else begin
        xr[g+1] <= xr[g] - (yr[g] >>> g);
        yr[g+1] <= yr[g] + (xr[g] >>> g);
        zr[g+1] <= zr[g] - $signed(ZW'(atan_deg(g)));
      end
      zf[g+1] <= zf[g];
    end
  end

  assign z_out = zf[STAGES] ? '0 : zr[STAGES];

endmodule

### sv/qhd_back.sv
// back end: two cordic pipelines, acceleration divide, rounding and result register
module qhd_back import qhd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  qhd_item_t          in_item,
  output logic               done,
  output logic               frame_ok,
  output logic [15:0]        azimuth,
  output logic signed [15:0] elevation,
  output logic signed [ACC_W-1:0] accel_z
);

  localparam int SH = ZFRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (SH - 1);
  localparam logic signed [ZW-1:0] FULL = ZW'(360) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] LIM  = ZW'(180) <<< ANGLE_FRAC_BITS;

  logic [ACC_W-1:0]        q;
  logic [23:0]             q50;
  logic [ACC_W-1:0]        qc;
  logic signed [ACC_W-1:0] acc;

  logic signed [ACC_W-1:0] acc_d [CORDIC_STAGES+1];
  logic                    ok_d  [CORDIC_STAGES+1];
  logic                    vld_d [CORDIC_STAGES+1];

  logic signed [ZW-1:0] z_az, z_el, r_az, r_el, w_az, c_el;

  assign q   = in_item.acc_prod[RECIP_SH +: ACC_W];
  assign q50 = 24'(q) * 24'(ACC_DIV);
  assign qc  = (q50 > 24'(in_item.acc_n)) ? q - 1'b1 : q;
  assign acc = in_item.acc_neg ? -$signed(qc) : $signed(qc);

  qhd_cordic #(.STAGES(CORDIC_STAGES)) u_az (
    .clk   (clk),
    .x_in  (in_item.az_x),
    .y_in  (in_item.az_y),
    .z_out (z_az)
  );

  qhd_cordic #(.STAGES(CORDIC_STAGES)) u_el (
    .clk   (clk),
    .x_in  (in_item.el_x),
    .y_in  (in_item.el_y),
    .z_out (z_el)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d[0] <= 1'b0;
    end else begin
      vld_d[0] <= in_valid;
    end
    acc_d[0] <= acc;
    ok_d[0]  <= in_item.ok;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_d[g+1] <= 1'b0;
      end else begin
        vld_d[g+1] <= vld_d[g];
      end
      acc_d[g+1] <= acc_d[g];
      ok_d[g+1]  <= ok_d[g];
    end
  end

  assign r_az = (HALF - z_az) >>> SH;
  assign r_el = (HALF - z_el) >>> SH;

  always_comb begin
    w_az = r_az;
    if (r_az < 0) begin
      w_az = r_az + FULL;
    end else if (r_az >= FULL) begin
      w_az = r_az - FULL;
    end
    c_el = r_el;
    if (r_el > LIM) begin
      c_el = LIM;
    end else if (r_el < -LIM) begin
      c_el = -LIM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_d[CORDIC_STAGES];
    end
    frame_ok  <= ok_d[CORDIC_STAGES];
    azimuth   <= ok_d[CORDIC_STAGES] ? w_az[15:0] : 16'd0;
    elevation <= ok_d[CORDIC_STAGES] ? c_el[15:0] : 16'sd0;
    accel_z   <= ok_d[CORDIC_STAGES] ? acc_d[CORDIC_STAGES] : '0;
  end

endmodule

### sv/quaternion_heading_decoder_top.sv
// top level of the quaternion heading decoder
// Takes one frame per clock (start while busy is low) and gives exactly one result per
// frame, marked by done for one cycle; each request passes the front registers, the queue,
// the two parallel pipelined cordic chains (one stage per micro-rotation) and the result
// register. Results cannot be held off, so busy stays low in normal use.
module quaternion_heading_decoder_top import qhd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         frame_length,
  input  logic signed [15:0] quat_i,
  input  logic signed [15:0] quat_j,
  input  logic signed [15:0] quat_k,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] accel_raw,
  output logic               done,
  output logic               frame_ok,
  output logic [15:0]        azimuth,
  output logic signed [15:0] elevation,
  output logic signed [17:0] accel_z
);

  logic      f_valid;
  qhd_item_t f_item;
  logic      q_full;
  logic      q_valid;
  qhd_item_t q_item;

  assign busy = q_full;

  qhd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .frame_length (frame_length),
    .quat_i       (quat_i),
    .quat_j       (quat_j),
    .quat_k       (quat_k),
    .quat_w       (quat_w),
    .accel_raw    (accel_raw),
    .out_valid    (f_valid),
    .out_item     (f_item)
  );

  qhd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  qhd_back #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STAGES   (CORDIC_STAGES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .done      (done),
    .frame_ok  (frame_ok),
    .azimuth   (azimuth),
    .elevation (elevation),
    .accel_z   (accel_z)
  );

endmodule

### sv/qhd_checker.sv
// port-level checks of the quaternion heading decoder and their bind
module qhd_checker #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STAGES   = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               frame_ok,
  input logic [15:0]        azimuth,
  input logic signed [15:0] elevation,
  input logic signed [17:0] accel_z
);

  localparam int LAT = CORDIC_STAGES + 5;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("result missing after request");

  a_az_range: assert property (@(posedge clk) disable iff (rst)
    done |-> 32'(azimuth) < (360 << ANGLE_FRAC_BITS))
    else $error("azimuth out of range");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && !frame_ok |-> azimuth == 16'd0 && elevation == 16'sd0 && accel_z == 18'sd0)
    else $error("bad frame with nonzero fields");

endmodule

bind quaternion_heading_decoder_top qhd_checker #(
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
  .CORDIC_STAGES   (CORDIC_STAGES)
) u_qhd_checker (.*);

### tb/quaternion_heading_decoder_top_tb.sv
// testbench for the quaternion heading decoder: directed table, then random frames checked against a cordic predictor
module quaternion_heading_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC   = 7;
  localparam int STAGES = 16;
  localparam int LAT    = STAGES + 5;
  localparam int N_RAND = 630;

  typedef struct {
    logic [9:0]         len;
    logic signed [15:0] qi, qj, qk, qw, raw;
  } frame_t;

  typedef struct {
    logic               ok;
    logic [15:0]        az;
    logic signed [15:0] el;
    logic signed [17:0] acc;
  } heading_t;

  typedef struct {
    frame_t   f;
    bit       typed;
    heading_t h;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, frame_ok;
  logic [9:0] frame_length = '0;
  logic signed [15:0] quat_i = '0, quat_j = '0, quat_k = '0, quat_w = '0, accel_raw = '0;
  logic [15:0] azimuth;
  logic signed [15:0] elevation;
  logic signed [17:0] accel_z;

  heading_t headings_due[$];
  int errors = 0;
  int idle_pct = 0;

  quaternion_heading_decoder_top #(.ANGLE_FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) uut (
    .clk, .rst, .start, .busy, .frame_length, .quat_i, .quat_j, .quat_k, .quat_w,
    .accel_raw, .done, .frame_ok, .azimuth, .elevation, .accel_z
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int n);
    longint tab[24] = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                        15018523, 7509720, 3754917, 1877466, 938734, 469367,
                        234684, 117342, 58671, 29335, 14668, 7334,
                        3667, 1833, 917, 458, 229, 115};
    return tab[n];
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        z = longint'(90) <<< 24;
        x = y;
        y = -t;
      end else begin
        z = -(longint'(90) <<< 24);
        x = -y;
        y = t;
      end
    end
    for (int n = 0; n < STAGES && n < 24; n++) begin
      xs = floor_shr(x, n);
      ys = floor_shr(y, n);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z += atan_step(n);
      end else begin
        x = x - ys;
        y = y + xs;
        z -= atan_step(n);
      end
    end
    return z;
  endfunction

  function automatic longint round_deg(longint v);
    int s;
    s = 24 - FRAC;
    return floor_shr(v + (longint'(1) <<< (s - 1)), s);
  endfunction

  function automatic heading_t decode_heading(frame_t f);
    heading_t h;
    longint i, j, k, w, az, el, num, acc, full, lim;
    h = '{1'b0, '0, '0, '0};
    if (f.len != 10'd16) return h;
    i = f.qi; j = f.qj; k = f.qk; w = f.qw;
    full = longint'(360) <<< FRAC;
    lim = longint'(180) <<< FRAC;
    az = round_deg(-vector_angle(2 * (i * j + k * w), i * i - j * j - k * k + w * w));
    if (az < 0) az += full;
    if (az >= full) az -= full;
    el = round_deg(-vector_angle(2 * (j * k + i * w), -i * i - j * j + k * k + w * w));
    if (el > lim) el = lim;
    if (el < -lim) el = -lim;
    num = longint'(f.raw) * 128 + 25;
    if (num >= 0) acc = num / 50;
    else acc = -((-num + 49) / 50);
    h.ok = 1'b1;
    h.az = az[15:0];
    h.el = el[15:0];
    h.acc = acc[17:0];
    return h;
  endfunction

  task automatic send_request(frame_t f, bit typed, heading_t h);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    frame_length <= f.len;
    quat_i <= f.qi; quat_j <= f.qj; quat_k <= f.qk; quat_w <= f.qw;
    accel_raw <= f.raw;
    while (busy) @(negedge clk);
    @(posedge clk);
    headings_due.push_back(typed ? h : decode_heading(f));
    @(negedge clk);
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    int m;
    m = $urandom_range(9);
    f.len = (m == 0) ? 10'($urandom_range(512)) : 10'd16;
    f.qi = 16'($urandom); f.qj = 16'($urandom); f.qk = 16'($urandom); f.qw = 16'($urandom);
    f.raw = 16'($urandom);
    if (m >= 6) begin
      // small i and j components, with k zero when m is 9
      f.qi = 16'($urandom_range(32)) - 16'sd16;
      f.qj = 16'($urandom_range(32)) - 16'sd16;
      if (m == 9) f.qk = '0; else f.qk = 16'($urandom_range(32768)) - 16'sd16384;
      f.qw = 16'($urandom_range(32768)) - 16'sd16384;
    end
    return f;
  endfunction

  always @(posedge clk) begin
    heading_t e;
    if (!rst && done) begin
      if (headings_due.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = headings_due.pop_front();
        if (frame_ok !== e.ok) begin
          $error("frame_ok expected %0d got %0d", e.ok, frame_ok); errors++;
        end
        if (azimuth !== e.az) begin
          $error("azimuth expected %0d got %0d", e.az, azimuth); errors++;
        end
        if (elevation !== e.el) begin
          $error("elevation expected %0d got %0d", e.el, elevation); errors++;
        end
        if (accel_z !== e.acc) begin
          $error("accel_z expected %0d got %0d", e.acc, accel_z); errors++;
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    row_t rows[$];
    frame_t f;
    rows = '{
      '{'{10'd16, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b1,
        '{1'b1, 16'd0, 16'sd0, 18'sd0}},
      '{'{10'd16, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
        '{1'b1, 16'd0, 16'sd0, 18'sd0}},
      '{'{10'd0, 16'sd100, 16'sd200, 16'sd300, 16'sd400, 16'sd500}, 1'b1,
        '{1'b0, 16'd0, 16'sd0, 18'sd0}},
      '{'{10'd512, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1,
        '{1'b0, 16'd0, 16'sd0, 18'sd0}},
      '{'{10'd1023, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
        '{1'b0, 16'd0, 16'sd0, 18'sd0}},
      '{'{10'd17, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd100}, 1'b1,
        '{1'b0, 16'd0, 16'sd0, 18'sd0}},
      '{'{10'd16, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd100}, 1'b1,
        '{1'b1, 16'd0, 16'sd0, 18'sd256}},
      '{'{10'd16, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd100}, 1'b1,
        '{1'b1, 16'd0, 16'sd0, -18'sd256}},
      '{'{10'd16, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff}, 1'b0, '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768}, 1'b0, '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd1}, 1'b0,
        '{1'b0, 0, 0, 0}},
      '{'{10'd16, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd1}, 1'b0,
        '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1'b0, '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 16'sd0}, 1'b0, '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sd0, 16'sd11585, 16'sd0, 16'sd11585, 16'sd0}, 1'b0, '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 16'sd0}, 1'b0, '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sd0, 16'sd0, 16'sd1, -16'sd16384, 16'sd0}, 1'b0, '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sd16384, 16'sd0, -16'sd1, 16'sd0, 16'sd0}, 1'b0, '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sd0, 16'sd16384, 16'sd0, 16'sd1, 16'sd0}, 1'b0, '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sd2, 16'sd0, 16'sd0, -16'sd16384, 16'sd50}, 1'b0, '{1'b0, 0, 0, 0}},
      '{'{10'd16, 16'sh5555, -16'sh5556, 16'sh2aaa, -16'sh2aab, 16'sh5555}, 1'b0,
        '{1'b0, 0, 0, 0}}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[r]) send_request(rows[r].f, rows[r].typed, rows[r].h);
    // hold off until the pipeline is empty
    while (headings_due.size() != 0) begin
      start <= 1'b0;
      @(negedge clk);
    end
    for (int n = 0; n < N_RAND; n++) begin
      idle_pct = (n < 210) ? 37 : (n < 420) ? 73 : 0;
      if (n == 300) begin
        while (headings_due.size() != 0) begin
          start <= 1'b0;
          @(negedge clk);
        end
      end
      f = random_frame();
      send_request(f, 1'b0, '{1'b0, 0, 0, 0});
    end
    start <= 1'b0;
    for (int c = 0; c < 20 * LAT && headings_due.size() != 0; c++) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
    if (errors == 0 && headings_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (headings_due.size() != 0) $error("%0d results never arrived", headings_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### quaternion_heading_decoder_top.f
sv/qhd_pkg.sv
sv/qhd_front.sv
sv/qhd_queue.sv
sv/qhd_cordic.sv
sv/qhd_back.sv
sv/quaternion_heading_decoder_top.sv
sv/qhd_checker.sv
tb/quaternion_heading_decoder_top_tb.sv
